// File: sv/priority_scheduler_with_aging_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the priority scheduler.
// Shared property wrappers used by the modules that carry checks.
// ---------------------------------------------------------------------------
`ifndef PRIORITY_SCHEDULER_WITH_AGING_MACROS_SVH
`define PRIORITY_SCHEDULER_WITH_AGING_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define PSA_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Checks that the antecedent implies the consequent in the next cycle.
`define PSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: sv/psa_pkg.sv
// ---------------------------------------------------------------------------
// Priority scheduler package
// Shared constants and types of the priority scheduler.
// ---------------------------------------------------------------------------
package psa_pkg;
  localparam int unsigned MaxTasks = 16;
  localparam int unsigned IdW = 4;
  localparam int unsigned LenW = 5;
  localparam int unsigned PrioW = 6;
  localparam logic signed [PrioW-1:0] PrioMin = -6'sd20;
  localparam logic signed [PrioW-1:0] PrioMax = 6'sd20;

  typedef enum logic [2:0] {
    FuncCreate  = 3'd0,
    FuncRequeue = 3'd1,
    FuncSetPrio = 3'd2,
    FuncGetPrio = 3'd3,
    FuncPick    = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    StOk    = 2'd0,
    StEmpty = 2'd1,
    StFull  = 2'd2,
    StRange = 2'd3
  } status_e;
endpackage

// File: sv/psa_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with a registered read.
// ---------------------------------------------------------------------------
module psa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// File: sv/priority_scheduler_with_aging.sv
// A pick loads its result into the output register after sweeping the queue
// memory: a first sweep finds the winner, with a queue read, a dynamic
// priority read and a compare for each entry, and a second sweep at the same
// pace closes the gap and ages each other task once; a single queued entry
// skips the second sweep. Create, requeue and set priority load their result
// from the operation state, get priority from the get state, once the static
// priority has been read. One item is in work at a time; the next item can be
// accepted once the scheduler is idle again and the output register is empty
// or being taken. Reset needs no clearing pass: the priority stores carry one
// valid bit per task id.
// ---------------------------------------------------------------------------
// Priority scheduler with aging
// Ready queue with static and dynamic priorities, aging on each pick.
// ---------------------------------------------------------------------------
module priority_scheduler_with_aging
  import psa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // func[2:0], task_id[6:3], new_prio[12:7]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata   // picked_id, picked_valid, prio_out, status
);
  `include "priority_scheduler_with_aging_macros.svh"

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SOp   = 4'd1;
  localparam logic [3:0] SGet  = 4'd2;
  localparam logic [3:0] SScRd = 4'd3;
  localparam logic [3:0] SScDp = 4'd4;
  localparam logic [3:0] SScCm = 4'd5;
  localparam logic [3:0] SRel  = 4'd6;
  localparam logic [3:0] SAgRd = 4'd7;
  localparam logic [3:0] SAgDp = 4'd8;
  localparam logic [3:0] SAgWr = 4'd9;
  localparam logic [3:0] SOut  = 4'd10;

  logic [3:0] state_q, state_d;
  logic [2:0] func_q;
  logic [IdW-1:0] id_q;
  logic signed [PrioW-1:0] np_q;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] idx_q, idx_d;
  logic [IdW-1:0] best_pos_q, best_id_q, cur_id_q;
  logic signed [PrioW-1:0] best_pr_q;
  logic [MaxTasks-1:0] sp_vld_q, dp_vld_q, seen_q;
  logic out_vld_q;
  logic [15:0] out_q;

  logic q_we, sp_we, dp_we;
  logic [IdW-1:0] q_wa, q_ra, q_wd, q_rd, sp_wa, sp_ra, dp_wa, dp_ra;
  logic [PrioW-1:0] sp_wd, sp_rd_raw, dp_wd, dp_rd_raw;
  logic signed [PrioW-1:0] sp_rd, dp_rd;
  logic [IdW-1:0] sp_ra_q, dp_ra_q;

  psa_ram #(.Width(IdW), .Depth(MaxTasks)) u_queue (
    .clk_i, .we_i(q_we), .waddr_i(q_wa), .wdata_i(q_wd), .raddr_i(q_ra), .rdata_o(q_rd));
  psa_ram #(.Width(PrioW), .Depth(MaxTasks)) u_sprio (
    .clk_i, .we_i(sp_we), .waddr_i(sp_wa), .wdata_i(sp_wd), .raddr_i(sp_ra),
    .rdata_o(sp_rd_raw));
  psa_ram #(.Width(PrioW), .Depth(MaxTasks)) u_dprio (
    .clk_i, .we_i(dp_we), .waddr_i(dp_wa), .wdata_i(dp_wd), .raddr_i(dp_ra),
    .rdata_o(dp_rd_raw));

  always_ff @(posedge clk_i) begin
    sp_ra_q <= sp_ra;
    dp_ra_q <= dp_ra;
  end
  assign sp_rd = sp_vld_q[sp_ra_q] ? $signed(sp_rd_raw) : '0;
  assign dp_rd = dp_vld_q[dp_ra_q] ? $signed(dp_rd_raw) : '0;

  assign s_axis_tready = (state_q == SIdle) && (!out_vld_q || m_axis_tready);
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  logic in_acc;
  logic out_ld;
  logic [IdW-1:0] o_pid;
  logic o_pv;
  logic [PrioW-1:0] o_pr;
  logic [1:0] o_st;
  logic signed [PrioW-1:0] aged;
  logic [LenW-1:0] last_idx;
  logic take_best;

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign last_idx = len_q - LenW'(1);
  assign aged = (dp_rd > PrioMin) ? dp_rd - PrioW'(1) : dp_rd;
  assign take_best = (idx_q == '0) || (dp_rd < best_pr_q);

  always_comb begin
    state_d = state_q;
    len_d = len_q;
    idx_d = idx_q;
    q_we = 1'b0; q_wa = len_q[IdW-1:0]; q_wd = id_q; q_ra = idx_q[IdW-1:0];
    sp_we = 1'b0; sp_wa = id_q; sp_wd = np_q; sp_ra = id_q;
    dp_we = 1'b0; dp_wa = id_q; dp_wd = np_q; dp_ra = id_q;
    out_ld = 1'b0;
    o_pid = '0; o_pv = 1'b0; o_pr = '0; o_st = StOk;
    unique case (state_q)
      SIdle: begin
        if (in_acc) begin
          state_d = SOp;
        end
      end
      SOp: begin
        unique case (func_q) inside
          FuncCreate, FuncRequeue: begin
            out_ld = 1'b1;
            state_d = SIdle;
            if (len_q == LenW'(MaxTasks)) begin
              o_st = StFull;
            end else begin
              q_we = 1'b1;
              len_d = len_q + LenW'(1);
              if (func_q == FuncCreate) begin
                sp_we = 1'b1; sp_wd = '0;
                dp_we = 1'b1; dp_wd = '0;
              end
            end
          end
          FuncSetPrio: begin
            out_ld = 1'b1;
            state_d = SIdle;
            if (np_q < PrioMin || np_q > PrioMax) begin
              o_st = StRange;
            end else begin
              sp_we = 1'b1;
              dp_we = 1'b1;
            end
          end
          FuncGetPrio: state_d = SGet;
          FuncPick: begin
            if (len_q == '0) begin
              out_ld = 1'b1;
              o_st = StEmpty;
              state_d = SIdle;
            end else begin
              idx_d = '0;
              state_d = SScRd;
            end
          end
          default: begin
            out_ld = 1'b1;
            state_d = SIdle;
          end
        endcase
      end
      SGet: begin
        out_ld = 1'b1;
        o_pr = sp_rd;
        state_d = SIdle;
      end
      SScRd: state_d = SScDp;
      SScDp: begin
        dp_ra = q_rd;
        state_d = SScCm;
      end
      SScCm: begin
        if (idx_q == last_idx) begin
          sp_ra = take_best ? cur_id_q : best_id_q;
          state_d = SRel;
        end else begin
          idx_d = idx_q + LenW'(1);
          state_d = SScRd;
        end
      end
      SRel: begin
        dp_we = 1'b1; dp_wa = best_id_q; dp_wd = sp_rd;
        idx_d = LenW'(best_pos_q);
        state_d = (len_q == LenW'(1)) ? SOut : SAgRd;
        if (len_q != LenW'(1)) idx_d = '0;
      end
      SAgRd: state_d = SAgDp;
      SAgDp: begin
        dp_ra = q_rd;
        state_d = SAgWr;
      end
      SAgWr: begin
        if (idx_q > LenW'(best_pos_q)) begin
          q_we = 1'b1;
          q_wa = idx_q[IdW-1:0] - IdW'(1);
          q_wd = cur_id_q;
        end
        if (idx_q != LenW'(best_pos_q) && !seen_q[cur_id_q]) begin
          dp_we = 1'b1; dp_wa = cur_id_q; dp_wd = aged;
        end
        if (idx_q == last_idx) begin
          state_d = SOut;
        end else begin
          idx_d = idx_q + LenW'(1);
          state_d = SAgRd;
        end
      end
      SOut: begin
        out_ld = 1'b1;
        o_pid = best_id_q;
        o_pv = 1'b1;
        len_d = last_idx;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      func_q <= s_axis_tdata[2:0];
      id_q <= s_axis_tdata[6:3];
      np_q <= $signed(s_axis_tdata[12:7]);
    end
    if (state_q == SScDp || state_q == SAgDp) cur_id_q <= q_rd;
    if (state_q == SScCm && take_best) begin
      best_pr_q <= dp_rd;
      best_pos_q <= idx_q[IdW-1:0];
      best_id_q <= cur_id_q;
    end
    if (out_ld) out_q <= {3'b0, o_st, o_pr, o_pv, o_pid};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      len_q <= '0;
      idx_q <= '0;
      sp_vld_q <= '0;
      dp_vld_q <= '0;
      seen_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q <= len_d;
      idx_q <= idx_d;
      if (sp_we) sp_vld_q[sp_wa] <= 1'b1;
      if (dp_we) dp_vld_q[dp_wa] <= 1'b1;
      if (state_q == SRel) seen_q <= MaxTasks'(1) << best_id_q;
      else if (state_q == SAgWr) seen_q[cur_id_q] <= 1'b1;
      if (out_ld) out_vld_q <= 1'b1;
      else if (m_axis_tready) out_vld_q <= 1'b0;
    end
  end

  `PSA_ASSERT(a_len_max, len_q <= LenW'(MaxTasks))
  `PSA_ASSERT(a_rdy_idle, !s_axis_tready || state_q == SIdle)
  `PSA_ASSERT_NEXT(a_pick_out, state_q == SOut, out_vld_q && out_q[4])
endmodule
